// File: sv/tlu_pkg.sv
// ----------------------------------------------------------------------------
// tlu_pkg
// Shared types and constants for the streaming tridiagonal LU factoriser.
// ----------------------------------------------------------------------------
package tlu_pkg;

    localparam int DATA_W = 32;
    localparam int ROW_W  = 17;
    localparam int STAT_W = 2;

    // defaults for the top-level parameters
    localparam int TLU_MAX_ROWS  = 65536;
    localparam int TLU_FRAC_BITS = 16;

    // largest value the row number field can carry
    localparam int ROW_FIELD_MAX = 131071;

    // quotient bits produced by the divider (33 covers the saturation range)
    localparam int QUO_BITS = 33;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO_PIVOT = 2'd1;
    localparam logic [STAT_W-1:0] ST_BW_ERR     = 2'd2;
    localparam logic [STAT_W-1:0] ST_SAT        = 2'd3;

    // register indexes on the configuration port
    localparam logic CFG_LOWER_BW = 1'b0;
    localparam logic CFG_UPPER_BW = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // take a new row
        logic prep;      // form magnitudes, check quotient overflow
        logic div_step;  // one restoring division step
        logic form_mul;  // sign and saturate the quotient
        logic product;   // multiplier times upper entry
        logic update;    // subtract, saturate, store the pivot
        logic out_load;  // copy the result into the output register
    } tlu_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic fast;      // row needs no division
    } tlu_stat_t;

endpackage

// File: sv/tlu_dpath.sv
// ----------------------------------------------------------------------------
// tlu_dpath
// Datapath: row registers, configuration, shared radix-2 divider, multiplier,
// saturating pivot update and the output register.
// ----------------------------------------------------------------------------
module tlu_dpath #(
    parameter int MAX_ROWS  = tlu_pkg::TLU_MAX_ROWS,
    parameter int FRAC_BITS = tlu_pkg::TLU_FRAC_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tlu_pkg::tlu_cmd_t                cmd,
    output tlu_pkg::tlu_stat_t               stat,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic                             cfg_data,
    input  logic signed [tlu_pkg::DATA_W-1:0] diag_entry,
    input  logic signed [tlu_pkg::DATA_W-1:0] upper_entry,
    input  logic signed [tlu_pkg::DATA_W-1:0] lower_entry,
    input  logic                             first_row,
    input  logic                             last_row,
    output logic signed [tlu_pkg::DATA_W-1:0] pivot,
    output logic signed [tlu_pkg::DATA_W-1:0] multiplier,
    output logic [tlu_pkg::ROW_W-1:0]        row_number,
    output logic [tlu_pkg::STAT_W-1:0]       status,
    output logic                             end_of_matrix
);
    import tlu_pkg::*;

    localparam int DVD_W     = DATA_W + FRAC_BITS;
    localparam int ROW_LIMIT = (MAX_ROWS < ROW_FIELD_MAX) ? MAX_ROWS : ROW_FIELD_MAX;
    localparam logic [ROW_W-1:0] ROW_LIM = ROW_W'(ROW_LIMIT);
    localparam logic [QUO_BITS-1:0] POS_MAX = QUO_BITS'(33'h0_7FFF_FFFF);
    localparam logic [QUO_BITS-1:0] NEG_MAX = QUO_BITS'(33'h0_8000_0000);

    // state with reset values
    logic signed [DATA_W-1:0] pp_reg, pp_next;
    logic [ROW_W-1:0]         row_cnt_reg, row_cnt_next;
    logic                     lbw_reg, ubw_reg;

    // row and working registers
    logic signed [DATA_W-1:0]   diag_reg, upper_reg, lower_reg;
    logic                       last_reg;
    logic [DATA_W-1:0]          dsr_reg;
    logic [DATA_W-1:0]          rem_reg;
    logic [QUO_BITS-1:0]        dq_reg;
    logic                       neg_reg, ovf_reg;
    logic signed [DATA_W-1:0]   mul_reg;
    logic                       qsat_reg;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [DATA_W-1:0]   res_piv_reg, res_mul_reg;
    logic [STAT_W-1:0]          res_stat_reg;

    // output register
    logic signed [DATA_W-1:0] out_piv_reg, out_mul_reg;
    logic [ROW_W-1:0]         out_row_reg;
    logic [STAT_W-1:0]        out_stat_reg;
    logic                     out_last_reg;

    logic                     bw_err;
    logic [ROW_W-1:0]         row_base;
    logic [DATA_W-1:0]        abs_lower, abs_pp;
    logic [DVD_W-1:0]         abs_num;
    logic [DATA_W-1:0]        rem_init;
    logic [DATA_W:0]          trial;
    logic                     qbit;
    logic                     qsat;
    logic [QUO_BITS-1:0]      qneg;
    logic signed [DATA_W-1:0] mul_val;
    logic signed [2*DATA_W-1:0] scaled;
    logic signed [2*DATA_W:0] diff;
    logic                     dsat;
    logic signed [DATA_W-1:0] piv_val;

    assign bw_err    = !lbw_reg || !ubw_reg;
    assign stat.fast = bw_err || first_row || (pp_reg == '0);

    always_comb
    begin
        row_base     = first_row ? '0 : row_cnt_reg;
        row_cnt_next = (row_base < ROW_LIM) ? row_base + 1'b1 : row_base;
    end

    // divider set-up: magnitudes and overflow of the top quotient bits
    always_comb
    begin
        abs_lower = lower_reg[DATA_W-1] ? DATA_W'(-lower_reg) : DATA_W'(lower_reg);
        abs_pp    = pp_reg[DATA_W-1] ? DATA_W'(-pp_reg) : DATA_W'(pp_reg);
        abs_num   = {abs_lower, {FRAC_BITS{1'b0}}};
        rem_init  = DATA_W'(abs_num[DVD_W-1:QUO_BITS]);
    end

    // restoring step
    always_comb
    begin
        trial = {rem_reg, dq_reg[QUO_BITS-1]};
        qbit  = (trial >= {1'b0, dsr_reg});
    end

    // sign and saturate the quotient
    always_comb
    begin
        qneg = -dq_reg;
        if (neg_reg)
            qsat = ovf_reg || (dq_reg > NEG_MAX);
        else
            qsat = ovf_reg || (dq_reg > POS_MAX);
        if (qsat)
            mul_val = neg_reg ? $signed(32'h8000_0000) : $signed(32'h7FFF_FFFF);
        else
            mul_val = neg_reg ? $signed(qneg[DATA_W-1:0]) : $signed(dq_reg[DATA_W-1:0]);
    end

    // floor scaling and saturating subtract
    always_comb
    begin
        scaled = prod_reg >>> FRAC_BITS;
        diff   = {{(DATA_W+1){diag_reg[DATA_W-1]}}, diag_reg} - {scaled[2*DATA_W-1], scaled};
        dsat   = (diff[2*DATA_W:DATA_W-1] != '0) && (diff[2*DATA_W:DATA_W-1] != '1);
        if (dsat)
            piv_val = diff[2*DATA_W] ? $signed(32'h8000_0000) : $signed(32'h7FFF_FFFF);
        else
            piv_val = diff[DATA_W-1:0];
    end

    always_comb
    begin
        pp_next = pp_reg;
        if (cmd.load && !bw_err && (first_row || pp_reg == '0))
            pp_next = diag_entry;
        else if (cmd.update)
            pp_next = piv_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_reg      <= '0;
            row_cnt_reg <= '0;
            lbw_reg     <= 1'b1;
            ubw_reg     <= 1'b1;
        end
        else
        begin
            pp_reg <= pp_next;
            if (cmd.load)
                row_cnt_reg <= row_cnt_next;
            if (cfg_we && cfg_index == CFG_LOWER_BW)
                lbw_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_UPPER_BW)
                ubw_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            diag_reg  <= diag_entry;
            upper_reg <= upper_entry;
            lower_reg <= lower_entry;
            last_reg  <= last_row;
            if (bw_err)
            begin
                res_piv_reg  <= '0;
                res_mul_reg  <= '0;
                res_stat_reg <= ST_BW_ERR;
            end
            else if (first_row)
            begin
                res_piv_reg  <= diag_entry;
                res_mul_reg  <= '0;
                res_stat_reg <= ST_OK;
            end
            else
            begin
                res_piv_reg  <= diag_entry;
                res_mul_reg  <= '0;
                res_stat_reg <= ST_ZERO_PIVOT;
            end
        end
        if (cmd.prep)
        begin
            dsr_reg <= abs_pp;
            rem_reg <= rem_init;
            dq_reg  <= abs_num[QUO_BITS-1:0];
            neg_reg <= lower_reg[DATA_W-1] ^ pp_reg[DATA_W-1];
            ovf_reg <= (rem_init >= abs_pp);
        end
        if (cmd.div_step)
        begin
            rem_reg <= qbit ? DATA_W'(trial - {1'b0, dsr_reg}) : trial[DATA_W-1:0];
            dq_reg  <= {dq_reg[QUO_BITS-2:0], qbit};
        end
        if (cmd.form_mul)
        begin
            mul_reg  <= mul_val;
            qsat_reg <= qsat;
        end
        if (cmd.product)
            prod_reg <= mul_reg * upper_reg;
        if (cmd.update)
        begin
            res_piv_reg  <= piv_val;
            res_mul_reg  <= mul_reg;
            res_stat_reg <= (qsat_reg || dsat) ? ST_SAT : ST_OK;
        end
        if (cmd.out_load)
        begin
            out_piv_reg  <= res_piv_reg;
            out_mul_reg  <= res_mul_reg;
            out_row_reg  <= row_cnt_reg;
            out_stat_reg <= res_stat_reg;
            out_last_reg <= last_reg;
        end
    end

    assign pivot         = out_piv_reg;
    assign multiplier    = out_mul_reg;
    assign row_number    = out_row_reg;
    assign status        = out_stat_reg;
    assign end_of_matrix = out_last_reg;

endmodule

// File: sv/tlu_ctrl.sv
// ----------------------------------------------------------------------------
// tlu_ctrl
// Controller: sequences one row through divide, multiply and update, and
// owns the input and output handshakes.
// ----------------------------------------------------------------------------
module tlu_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output tlu_pkg::tlu_cmd_t  cmd,
    input  tlu_pkg::tlu_stat_t stat
);
    import tlu_pkg::*;

    localparam int CNT_W = $clog2(QUO_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_BITS - 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PREP = 7'b0000010,
        S_DIV  = 7'b0000100,
        S_MULQ = 7'b0001000,
        S_PROD = 7'b0010000,
        S_SUB  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.fast ? S_DONE : S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = S_MULQ;
            end
            S_MULQ:
            begin
                cmd.form_mul = 1'b1;
                state_next   = S_PROD;
            end
            S_PROD:
            begin
                cmd.product = 1'b1;
                state_next  = S_SUB;
            end
            S_SUB:
            begin
                cmd.update = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.prep)
            cnt_next = '0;
        else if (cmd.div_step)
            cnt_next = cnt_reg + 1'b1;
        out_valid_next = cmd.out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: sv/tridiagonal_lu_factor_stream.sv
// ----------------------------------------------------------------------------
// tridiagonal_lu_factor_stream
// Row-by-row LU factorisation without pivoting of a tridiagonal matrix in
// signed fixed point, with saturation and error status.
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload
//  -------   -------------------   ------------------------------------------
//  in        in_valid / in_stall   diag_entry upper_entry lower_entry
//                                  first_row last_row
//  out       out_valid / out_stall pivot multiplier row_number status
//                                  end_of_matrix
//  cfg       cfg_valid / cfg_ready cfg_index cfg_data
//
//  A row that needs a division passes through set-up, the radix-2 restoring
//  divider, which produces one quotient bit a cycle, then multiply, update
//  and hand-over to the output register. First rows, rows after a zero
//  pivot and bandwidth errors go straight from the input beat to hand-over.
//  One row is in flight at a time; the next row is taken while a finished
//  result still sits in the output register.
//  Reset clears the previous pivot and row count and sets both bandwidths
//  to one. cfg_ready is always high.
//
module tridiagonal_lu_factor_stream #(
    parameter int MAX_ROWS  = tlu_pkg::TLU_MAX_ROWS,
    parameter int FRAC_BITS = tlu_pkg::TLU_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [tlu_pkg::DATA_W-1:0] diag_entry,
    input  logic signed [tlu_pkg::DATA_W-1:0] upper_entry,
    input  logic signed [tlu_pkg::DATA_W-1:0] lower_entry,
    input  logic                              first_row,
    input  logic                              last_row,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [tlu_pkg::DATA_W-1:0] pivot,
    output logic signed [tlu_pkg::DATA_W-1:0] multiplier,
    output logic [tlu_pkg::ROW_W-1:0]         row_number,
    output logic [tlu_pkg::STAT_W-1:0]        status,
    output logic                              end_of_matrix,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic                              cfg_data
);
    import tlu_pkg::*;

    tlu_cmd_t  cmd;
    tlu_stat_t stat;

    assign cfg_ready = 1'b1;

    tlu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    tlu_dpath #(
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .diag_entry    (diag_entry),
        .upper_entry   (upper_entry),
        .lower_entry   (lower_entry),
        .first_row     (first_row),
        .last_row      (last_row),
        .pivot         (pivot),
        .multiplier    (multiplier),
        .row_number    (row_number),
        .status        (status),
        .end_of_matrix (end_of_matrix)
    );

endmodule
